// ===== rtl/y2c_pkg.sv =====
// ----------------------------------------------------------------------------
// y2c_pkg
// Shared widths, register indexes and the output saturation function of the
// YIQ to YCbCr converter.
// ----------------------------------------------------------------------------
package y2c_pkg;

    localparam int COEF_FRAC_BITS = 16;
    localparam int OUT_WIDTH      = 16;

    // Input and register field widths.
    localparam int LUMA_IN_W   = 18;
    localparam int CHROMA_W    = 17;
    localparam int BLACK_W     = 16;
    localparam int GAIN_W      = 24;
    localparam int COEF_W      = 24;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_IDX_W   = 3;

    // Luma datapath widths.
    localparam int LDIFF_W  = LUMA_IN_W + 1;
    localparam int LPROD_W  = LDIFF_W + GAIN_W + 1;
    localparam int LSCL_W   = LPROD_W + 3;
    localparam int LFLR_W   = LSCL_W - COEF_FRAC_BITS - 2;

    // Chroma datapath widths.
    localparam int CPROD_W  = CHROMA_W + COEF_W;
    localparam int CSUM_W   = CPROD_W + 1;
    localparam int CFLR_W   = CSUM_W - COEF_FRAC_BITS;

    // Width of a value handed to the saturation stage.
    localparam int SAT_W    = 32;

    localparam logic signed [SAT_W-1:0] LUMA_OFFSET   = SAT_W'(16 <<< (OUT_WIDTH - 8));
    localparam logic signed [SAT_W-1:0] CHROMA_OFFSET = SAT_W'(128 <<< (OUT_WIDTH - 8));
    localparam logic signed [SAT_W-1:0] OUT_MAX       = SAT_W'((1 <<< OUT_WIDTH) - 1);

    localparam logic [GAIN_W-1:0] LUMA_GAIN_RST = GAIN_W'(65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLACK_LEVEL    = 3'd0,
        CFG_LUMA_GAIN      = 3'd1,
        CFG_WHITE_POINT_75 = 3'd2,
        CFG_CB_FROM_I      = 3'd3,
        CFG_CB_FROM_Q      = 3'd4,
        CFG_CR_FROM_I      = 3'd5,
        CFG_CR_FROM_Q      = 3'd6
    } t_cfg_idx;

    // Load enables of pipeline stages two to four.
    typedef struct packed {
        logic en2;
        logic en3;
        logic en4;
    } t_pipe_en;

    function automatic logic [OUT_WIDTH-1:0] f_sat(input logic signed [SAT_W-1:0] v);
        if (v < 0) begin
            return '0;
        end else if (v > OUT_MAX) begin
            return '1;
        end else begin
            return v[OUT_WIDTH-1:0];
        end
    endfunction

endpackage

// ===== rtl/y2c_pix_in_if.sv =====
// ----------------------------------------------------------------------------
// y2c_pix_in_if
// Valid/ready channel that carries one decoded YIQ pixel word.
// ----------------------------------------------------------------------------
interface y2c_pix_in_if
    import y2c_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic signed [LUMA_IN_W-1:0] luma_in;
    logic signed [CHROMA_W-1:0]  chroma_i;
    logic signed [CHROMA_W-1:0]  chroma_q;
    logic                        line_end;

    modport source (output valid, luma_in, chroma_i, chroma_q, line_end, input ready);
    modport sink   (input valid, luma_in, chroma_i, chroma_q, line_end, output ready);
endinterface

// ===== rtl/y2c_pix_out_if.sv =====
// ----------------------------------------------------------------------------
// y2c_pix_out_if
// Valid/ready channel that carries one YCbCr pixel word.
// ----------------------------------------------------------------------------
interface y2c_pix_out_if
    import y2c_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [OUT_WIDTH-1:0] luma_out;
    logic [OUT_WIDTH-1:0] cb_out;
    logic [OUT_WIDTH-1:0] cr_out;
    logic                 line_end_out;

    modport source (output valid, luma_out, cb_out, cr_out, line_end_out, input ready);
    modport sink   (input valid, luma_out, cb_out, cr_out, line_end_out, output ready);
endinterface

// ===== rtl/y2c_chroma_mac.sv =====
// ----------------------------------------------------------------------------
// y2c_chroma_mac
// One chroma output channel: two products, their sum floored, then offset
// and saturation. Occupies pipeline stages two to four.
// ----------------------------------------------------------------------------
module y2c_chroma_mac
    import y2c_pkg::*;
(
    input  logic                       i_clk,
    input  t_pipe_en                   i_en,
    input  logic signed [CHROMA_W-1:0] i_ci,
    input  logic signed [CHROMA_W-1:0] i_cq,
    input  logic signed [COEF_W-1:0]   i_wi,
    input  logic signed [COEF_W-1:0]   i_wq,
    output logic [OUT_WIDTH-1:0]       o_out
);

    logic signed [CPROD_W-1:0] r_pi;
    logic signed [CPROD_W-1:0] r_pq;
    logic signed [CFLR_W-1:0]  r_flr;
    logic [OUT_WIDTH-1:0]      r_out;

    logic signed [CSUM_W-1:0]  n_sum;
    logic signed [CFLR_W-1:0]  n_flr;
    logic [OUT_WIDTH-1:0]      n_out;

    always_comb begin
        n_sum = CSUM_W'(r_pi) + CSUM_W'(r_pq);
        // Dropping the fraction bits of a two's complement value floors it.
        n_flr = n_sum[CSUM_W-1:COEF_FRAC_BITS];
        n_out = f_sat(SAT_W'(r_flr) + CHROMA_OFFSET);
    end

    always_ff @(posedge i_clk) begin
        if (i_en.en2) begin
            r_pi <= i_ci * i_wi;
            r_pq <= i_cq * i_wq;
        end
        if (i_en.en3) begin
            r_flr <= n_flr;
        end
        if (i_en.en4) begin
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule

// ===== rtl/yiq_to_ycbcr_converter_core.sv =====
// ----------------------------------------------------------------------------
// yiq_to_ycbcr_converter_core
// Converts decoded luma and I/Q chroma to 16-bit YCbCr with saturation.
// ----------------------------------------------------------------------------
// The converter takes one pixel word per clock while the output is not stalled,
// and returns one YCbCr word for each, in order. Four register stages hold
// the work: black level subtraction, the multipliers, the 5/4 scaling and the
// product sums, then offset and saturation into the output register. Each
// stage has its own valid bit and moves up when the stage after it is free,
// so a stalled output only holds the words already in flight and the input
// keeps being taken until the pipeline is full. The user writes registers via the
// plain write port only while no pixel is in flight; this is not enforced.
module yiq_to_ycbcr_converter_core
    import y2c_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    y2c_pix_in_if.sink            i_pix,
    y2c_pix_out_if.source         o_pix
);

    // Configuration registers.
    logic [BLACK_W-1:0]        r_black_level;
    logic [GAIN_W-1:0]         r_luma_gain;
    logic                      r_white_point_75;
    logic signed [COEF_W-1:0]  r_cb_from_i;
    logic signed [COEF_W-1:0]  r_cb_from_q;
    logic signed [COEF_W-1:0]  r_cr_from_i;
    logic signed [COEF_W-1:0]  r_cr_from_q;

    // Stage valid bits.
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;

    logic     en1;
    t_pipe_en en;

    // Stage payload.
    logic signed [LDIFF_W-1:0]  r_ldiff;
    logic signed [CHROMA_W-1:0] r_ci;
    logic signed [CHROMA_W-1:0] r_cq;
    logic                       r_le1;
    logic signed [LPROD_W-1:0]  r_lprod;
    logic                       r_le2;
    logic signed [LFLR_W-1:0]   r_lflr;
    logic                       r_le3;
    logic [OUT_WIDTH-1:0]       r_luma;
    logic                       r_le4;

    logic signed [LDIFF_W-1:0]  n_ldiff;
    logic signed [LSCL_W-1:0]   n_lscl;
    logic signed [LFLR_W-1:0]   n_lflr;
    logic [OUT_WIDTH-1:0]       n_luma;
    logic [OUT_WIDTH-1:0]       cb;
    logic [OUT_WIDTH-1:0]       cr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_black_level    <= '0;
            r_luma_gain      <= LUMA_GAIN_RST;
            r_white_point_75 <= 1'b0;
            r_cb_from_i      <= '0;
            r_cb_from_q      <= '0;
            r_cr_from_i      <= '0;
            r_cr_from_q      <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BLACK_LEVEL:    r_black_level    <= i_cfg_data[BLACK_W-1:0];
                CFG_LUMA_GAIN:      r_luma_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_WHITE_POINT_75: r_white_point_75 <= i_cfg_data[0];
                CFG_CB_FROM_I:      r_cb_from_i      <= i_cfg_data[COEF_W-1:0];
                CFG_CB_FROM_Q:      r_cb_from_q      <= i_cfg_data[COEF_W-1:0];
                CFG_CR_FROM_I:      r_cr_from_i      <= i_cfg_data[COEF_W-1:0];
                CFG_CR_FROM_Q:      r_cr_from_q      <= i_cfg_data[COEF_W-1:0];
                default: ;
            endcase
        end
    end

    // A stage loads when it is empty or its word moves on in the same cycle.
    always_comb begin
        en.en4 = !r_v4 || o_pix.ready;
        en.en3 = !r_v3 || en.en4;
        en.en2 = !r_v2 || en.en3;
        en1    = !r_v1 || en.en2;
    end

    assign i_pix.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_pix.valid;
            end
            if (en.en2) begin
                r_v2 <= r_v1;
            end
            if (en.en3) begin
                r_v3 <= r_v2;
            end
            if (en.en4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_comb begin
        n_ldiff = LDIFF_W'(i_pix.luma_in) - LDIFF_W'(signed'({1'b0, r_black_level}));
        // The product is scaled by four so that both modes floor at the same bit:
        // four times for unity, five times for the 5/4 white point.
        n_lscl  = (LSCL_W'(r_lprod) <<< 2) + (r_white_point_75 ? LSCL_W'(r_lprod) : '0);
        n_lflr  = n_lscl[LSCL_W-1:COEF_FRAC_BITS+2];
        n_luma  = f_sat(SAT_W'(r_lflr) + LUMA_OFFSET);
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_ldiff <= n_ldiff;
            r_ci    <= i_pix.chroma_i;
            r_cq    <= i_pix.chroma_q;
            r_le1   <= i_pix.line_end;
        end
        if (en.en2) begin
            r_lprod <= LPROD_W'(r_ldiff) * LPROD_W'(signed'({1'b0, r_luma_gain}));
            r_le2   <= r_le1;
        end
        if (en.en3) begin
            r_lflr <= n_lflr;
            r_le3  <= r_le2;
        end
        if (en.en4) begin
            r_luma <= n_luma;
            r_le4  <= r_le3;
        end
    end

    y2c_chroma_mac u_cb (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ci  (r_ci),
        .i_cq  (r_cq),
        .i_wi  (r_cb_from_i),
        .i_wq  (r_cb_from_q),
        .o_out (cb)
    );

    y2c_chroma_mac u_cr (
        .i_clk (i_clk),
        .i_en  (en),
        .i_ci  (r_ci),
        .i_cq  (r_cq),
        .i_wi  (r_cr_from_i),
        .i_wq  (r_cr_from_q),
        .o_out (cr)
    );

    assign o_pix.valid        = r_v4;
    assign o_pix.luma_out     = r_luma;
    assign o_pix.cb_out       = cb;
    assign o_pix.cr_out       = cr;
    assign o_pix.line_end_out = r_le4;

endmodule
